[design/tcce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// types, constants and codes shared by the text console character engine
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int unsigned COLUMNS_DEF  = 80;
  localparam int unsigned ROWS_DEF     = 25;
  localparam int unsigned RESERVED_DEF = 1;

  localparam logic [15:0] BLANK_CELL      = 16'h0F20;
  localparam logic [7:0]  FIRST_PRINTABLE = 8'd32;
  localparam logic [7:0]  LAST_PRINTABLE  = 8'd126;
  localparam logic [7:0]  CODE_BS = 8'd8;
  localparam logic [7:0]  CODE_HT = 8'd9;
  localparam logic [7:0]  CODE_LF = 8'd10;
  localparam logic [7:0]  CODE_FF = 8'd12;
  localparam logic [7:0]  CODE_CR = 8'd13;

  localparam logic [1:0] REG_FG    = 2'd0;
  localparam logic [1:0] REG_BG    = 2'd1;
  localparam logic [1:0] REG_BLINK = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP, OP_PUT, OP_BS, OP_HT, OP_LF, OP_FF, OP_CR, OP_READ
  } op_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } op_item_t;

endpackage

[design/text_console_character_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_character_engine_top
// text console: character stream into a cell memory with a cursor
// ----------------------------------------------------------------------------
// usage:
//  - input beats are pushed with push while full is low; cmd 0 carries a
//    character byte, cmd 1 asks for one cell at read_row/read_col
//  - every input beat gives one result beat: cursor position and, for a
//    read, the cell word; taken with pop while empty is low
//  - a decode front end with a two-entry queue feeds the execution back end
//  - a character or a read beat shows its result once the back end has
//    executed it; the back end finishes one op before it takes the next,
//    and a read result comes from the registered read of the cell memory
//  - newline or wrap past the last row scrolls: each cell below the status
//    rows is copied up from the row beneath, then the last row is blanked
//  - form feed blanks the rows below the status line, one cell per cycle
//  - after reset every cell of the memory is filled with a blank; beats
//    are queued but not executed meanwhile
//  - if pop stays low the result holds and the back end stalls; the
//    front queue then fills and full rises
//  - apb registers: 0 foreground, 1 background, 2 blink
// ----------------------------------------------------------------------------
module text_console_character_engine_top
  import tcce_pkg::*;
#(
  parameter int unsigned COLUMNS  = COLUMNS_DEF,
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned RESERVED = RESERVED_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       fq_full, op_valid, op_take, res_valid;
  op_item_t   op;
  logic [3:0] fg_q;
  logic [2:0] bg_q;
  logic       blink_q;
  logic       cfg_wr;

  assign full   = fq_full;
  assign empty  = !res_valid;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register file, byte address 4*index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= 4'hF; bg_q <= '0; blink_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FG:    fg_q    <= pwdata[3:0];
        REG_BG:    bg_q    <= pwdata[2:0];
        REG_BLINK: blink_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_FG:    prdata = {28'd0, fg_q};
      REG_BG:    prdata = {29'd0, bg_q};
      REG_BLINK: prdata = {31'd0, blink_q};
      default: ;
    endcase
  end

  tcce_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .in_i(in_item_i), .full_o(fq_full),
    .op_valid_o(op_valid), .op_o(op), .op_take_i(op_take)
  );

  tcce_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .RESERVED(RESERVED)) u_back (
    .clk_i, .rst_ni,
    .op_valid_i(op_valid), .op_i(op), .op_take_o(op_take),
    .fg_i(fg_q), .bg_i(bg_q), .blink_i(blink_q),
    .res_valid_o(res_valid), .res_o(out_item_o), .res_take_i(pop)
  );

endmodule

[design/tcce_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_front
// accepts input beats, decodes them into operations, two-entry queue
// ----------------------------------------------------------------------------
module tcce_front
  import tcce_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_i,
  output logic     full_o,
  output logic     op_valid_o,
  output op_item_t op_o,
  input  logic     op_take_i
);

  op_item_t   slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       acc;
  op_item_t   dec;

  always_comb begin
    dec.char_code = in_i.char_code;
    dec.read_row  = in_i.read_row;
    dec.read_col  = in_i.read_col;
    if (in_i.cmd) begin
      dec.op = OP_READ;
    end else if (in_i.char_code >= FIRST_PRINTABLE && in_i.char_code <= LAST_PRINTABLE) begin
      dec.op = OP_PUT;
    end else begin
      unique case (in_i.char_code)
        CODE_BS: dec.op = OP_BS;
        CODE_HT: dec.op = OP_HT;
        CODE_LF: dec.op = OP_LF;
        CODE_FF: dec.op = OP_FF;
        CODE_CR: dec.op = OP_CR;
        default: dec.op = OP_NOP;
      endcase
    end
  end

  assign full_o     = (cnt_q == 2'd2);
  assign acc        = push_i && !full_o;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (acc && !(op_take_i && op_valid_o)) cnt_d = cnt_q + 2'd1;
    else if (!acc && op_take_i && op_valid_o) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (acc) wr_q <= !wr_q;
      if (op_take_i && op_valid_o) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) slot_q[wr_q] <= dec;
  end

endmodule

[design/tcce_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_back
// executes operations on the cell memory and cursor; sweeps for clear/scroll
// ----------------------------------------------------------------------------
module tcce_back
  import tcce_pkg::*;
#(
  parameter int unsigned COLUMNS  = COLUMNS_DEF,
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned RESERVED = RESERVED_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_valid_i,
  input  op_item_t   op_i,
  output logic       op_take_o,
  input  logic [3:0] fg_i,
  input  logic [2:0] bg_i,
  input  logic       blink_i,
  output logic       res_valid_o,
  output out_item_t  res_o,
  input  logic       res_take_i
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS + 1);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(CELLS - 1);
  localparam logic [AW-1:0] TOP_ADDR   = AW'(RESERVED * COLUMNS);
  localparam logic [AW-1:0] LROW_ADDR  = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [RW-1:0] TOP_ROW    = RW'(RESERVED);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_SCR_R = 3'd3;
  localparam logic [2:0] ST_SCR_W = 3'd4;
  localparam logic [2:0] ST_BLANK = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [15:0] mem [CELLS];
  logic [15:0] rdata_q;

  logic [2:0]    st_q, st_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          rvalid_q, rvalid_d;
  out_item_t     res_q, res_d;
  logic          busy_read_ok_q, busy_read_ok_d;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] rq_addr;
  logic          rq_ok;
  logic [CW:0]   tab_col;

  assign cur_addr = AW'(row_q * COLUMNS) + AW'(col_q);
  assign rq_ok    = (32'(op_i.read_row) < ROWS) && (32'(op_i.read_col) < COLUMNS);
  assign rq_addr  = AW'(op_i.read_row * COLUMNS) + AW'(op_i.read_col);
  assign tab_col  = {1'b0, (col_q & ~CW'(7))} + (CW + 1)'(8);

  assign res_valid_o = rvalid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_comb begin
    st_d = st_q; ptr_d = ptr_q; row_d = row_q; col_d = col_q;
    rd_en = 1'b0; rd_addr = rq_addr;
    wr_en = 1'b0; wr_addr = ptr_q; wr_data = BLANK_CELL;
    rvalid_d = rvalid_q; res_d = res_q; busy_read_ok_d = busy_read_ok_q;
    op_take_o = 1'b0;
    if (res_take_i && rvalid_q) rvalid_d = 1'b0;
    unique case (st_q)
      ST_CLR: begin
        wr_en = 1'b1;
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == LAST_ADDR) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (op_valid_i && !rvalid_d) begin
          op_take_o = 1'b1;
          st_d = ST_DONE;
          unique case (op_i.op)
            OP_PUT: begin
              wr_en   = 1'b1;
              wr_addr = cur_addr;
              wr_data = {blink_i, bg_i, fg_i, op_i.char_code};
              if (col_q == LAST_COL) begin
                col_d = '0;
                row_d = row_q + RW'(1);
                if (row_q == LAST_ROW) begin
                  ptr_d = TOP_ADDR; st_d = ST_SCR_R;
                end
              end else begin
                col_d = col_q + CW'(1);
              end
            end
            OP_BS: if (col_q != '0) col_d = col_q - CW'(1);
            OP_HT: col_d = (tab_col > (CW + 1)'(LAST_COL)) ? LAST_COL : tab_col[CW-1:0];
            OP_LF: begin
              col_d = '0;
              row_d = row_q + RW'(1);
              if (row_q == LAST_ROW) begin
                ptr_d = TOP_ADDR; st_d = ST_SCR_R;
              end
            end
            OP_FF: begin
              col_d = '0; row_d = TOP_ROW; ptr_d = TOP_ADDR; st_d = ST_BLANK;
            end
            OP_CR: col_d = '0;
            OP_READ: begin
              rd_en = 1'b1;
              busy_read_ok_d = rq_ok;
              st_d = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        rvalid_d = 1'b1;
        res_d.cursor_position = 11'(cur_addr);
        res_d.cell_data = busy_read_ok_q ? rdata_q : 16'h0000;
        st_d = ST_IDLE;
      end
      ST_SCR_R: begin
        if (ptr_q >= LROW_ADDR) begin
          st_d = ST_BLANK;
        end else begin
          rd_en = 1'b1;
          rd_addr = ptr_q + COLS_A;
          st_d = ST_SCR_W;
        end
      end
      ST_SCR_W: begin
        wr_en = 1'b1;
        wr_data = rdata_q;
        ptr_d = ptr_q + AW'(1);
        st_d = ST_SCR_R;
      end
      ST_BLANK: begin
        wr_en = 1'b1;
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == LAST_ADDR) st_d = ST_DONE;
      end
      ST_DONE: begin
        if (row_q > LAST_ROW) begin
          row_d = LAST_ROW; col_d = '0;
        end
        if (!rvalid_d) begin
          rvalid_d = 1'b1;
          res_d.cursor_position = (row_q > LAST_ROW) ? 11'(LROW_ADDR) : 11'(cur_addr);
          res_d.cell_data = 16'h0000;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLR; ptr_q <= '0; row_q <= '0; col_q <= '0;
      rvalid_q <= 1'b0; busy_read_ok_q <= 1'b0;
    end else begin
      st_q <= st_d; ptr_q <= ptr_d; row_q <= row_d; col_q <= col_d;
      rvalid_q <= rvalid_d; busy_read_ok_q <= busy_read_ok_d;
    end
  end

  always_ff @(posedge clk_i) res_q <= res_d;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the text console character engine against a cell-level predictor
// ----------------------------------------------------------------------------
// character and read beats go in through the queue-style input port. A local
// model of the cell memory and cursor predicts each result beat, and a
// monitor compares the beats in order. A directed set covers the code
// classes, the field extremes and out-of-range reads. Random traffic follows
// under three idling patterns, with color and blink changes in between.
// ----------------------------------------------------------------------------
module tb
  import tcce_pkg::*;
;

  localparam int NCOLS     = 80;
  localparam int NROWS     = 25;
  localparam int TOP_ROWS  = 1;
  localparam int TAB_W     = 8;
  localparam int WDOG_MAX  = 40000;
  localparam int SETTLE    = 64;
  localparam int PHASE_LEN = 550;

  localparam logic [3:0] ADDR_FG    = 4'(REG_FG) << 2;
  localparam logic [3:0] ADDR_BG    = 4'(REG_BG) << 2;
  localparam logic [3:0] ADDR_BLINK = 4'(REG_BLINK) << 2;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_READ = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // console model: cell memory, cursor and the active attributes
  logic [15:0] cell_mem [NROWS*NCOLS];
  int          cur_row;
  int          cur_col;
  logic [3:0]  attr_fg;
  logic [2:0]  attr_bg;
  logic        attr_blink;

  out_item_t   pending_q[$];
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          mismatches = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          scrolls = 0;
  int          wdog = 0;

  text_console_character_engine_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // ---- console model -------------------------------------------------------

  // blank every row from first_row down to the bottom
  function automatic void blank_from(input int first_row);
    for (int k = first_row * NCOLS; k < NROWS * NCOLS; k++) cell_mem[k] = BLANK_CELL;
  endfunction

  // apply one character byte to the model cursor and cell memory
  function automatic void console_char(input logic [7:0] code);
    if (code >= FIRST_PRINTABLE && code <= LAST_PRINTABLE) begin
      cell_mem[cur_row * NCOLS + cur_col] = {attr_blink, attr_bg, attr_fg, code};
      cur_col++;
      if (cur_col >= NCOLS) begin
        cur_col = 0;
        cur_row++;
      end
    end else if (code == CODE_BS) begin
      if (cur_col > 0) cur_col--;
    end else if (code == CODE_HT) begin
      cur_col = (cur_col / TAB_W + 1) * TAB_W;
      if (cur_col > NCOLS - 1) cur_col = NCOLS - 1;
    end else if (code == CODE_LF) begin
      cur_row++;
      cur_col = 0;
    end else if (code == CODE_FF) begin
      blank_from(TOP_ROWS);
      cur_row = TOP_ROWS;
      cur_col = 0;
    end else if (code == CODE_CR) begin
      cur_col = 0;
    end
    // past the bottom: everything under the status rows moves up one row
    if (cur_row >= NROWS) begin
      for (int k = TOP_ROWS * NCOLS; k < (NROWS - 1) * NCOLS; k++)
        cell_mem[k] = cell_mem[k + NCOLS];
      blank_from(NROWS - 1);
      cur_row = NROWS - 1;
      cur_col = 0;
      scrolls++;
    end
  endfunction

  // expected result beat for one accepted input beat
  function automatic out_item_t console_result(input in_item_t it);
    out_item_t r;
    r = '0;
    if (it.cmd == CMD_CHAR) begin
      console_char(it.char_code);
    end else if (it.read_row < NROWS && it.read_col < NCOLS) begin
      r.cell_data = cell_mem[it.read_row * NCOLS + it.read_col];
    end
    r.cursor_position = 11'(cur_row * NCOLS + cur_col);
    return r;
  endfunction

  // ---- stimulus helpers ----------------------------------------------------

  // push one beat, wait for acceptance, then maybe leave a gap
  task automatic send_beat(input in_item_t it);
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    pending_q.push_back(console_result(it));
    beats_in++;
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_char(input logic [7:0] code);
    in_item_t it;
    it           = '0;
    it.cmd       = CMD_CHAR;
    it.char_code = code;
    it.read_row  = 5'($urandom);
    it.read_col  = 7'($urandom);
    send_beat(it);
  endtask

  task automatic send_read(input logic [4:0] row, input logic [6:0] col);
    in_item_t it;
    it           = '0;
    it.cmd       = CMD_READ;
    it.char_code = 8'($urandom);
    it.read_row  = row;
    it.read_col  = col;
    send_beat(it);
  endtask

  // hold the input until every result is back, then let the back end settle
  task automatic drain;
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // two-phase register write; model picks up the value at the access edge
  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      ADDR_FG:    attr_fg    = data[3:0];
      ADDR_BG:    attr_bg    = data[2:0];
      ADDR_BLINK: attr_blink = data[0];
      default: ;
    endcase
  endtask

  task automatic set_attrs(input logic [3:0] fg, input logic [2:0] bg, input logic bl);
    drain();
    reg_write(ADDR_FG, {28'($urandom), fg});
    reg_write(ADDR_BG, {29'($urandom), bg});
    reg_write(ADDR_BLINK, {31'($urandom), bl});
  endtask

  // ---- tests ---------------------------------------------------------------

  // code classes, field extremes and reads outside the grid
  task automatic test_directed;
    send_char(8'd65);
    send_char(CODE_BS);
    send_char(CODE_BS);
    send_char(CODE_BS);
    send_char(FIRST_PRINTABLE);
    send_char(LAST_PRINTABLE);
    send_char(CODE_HT);
    send_char(CODE_CR);
    send_char(CODE_LF);
    send_char(8'd0);
    send_char(8'd31);
    send_char(8'd127);
    send_char(8'd255);
    send_char(CODE_FF);
    send_char(8'd90);
    send_read(5'd0, 7'd0);
    send_read(5'd0, 7'd1);
    send_read(5'd1, 7'd0);
    send_read(5'd24, 7'd79);
    send_read(5'd25, 7'd0);
    send_read(5'd0, 7'd80);
    send_read(5'd31, 7'd127);
  endtask

  // weighted random traffic, mostly text with some control and reads
  task automatic test_random(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 58) begin
        send_char(8'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE)));
      end else if (pick < 62) begin
        send_char(CODE_LF);
      end else if (pick < 63) begin
        send_char(CODE_FF);
      end else if (pick < 66) begin
        send_char(CODE_CR);
      end else if (pick < 70) begin
        send_char(CODE_BS);
      end else if (pick < 76) begin
        send_char(CODE_HT);
      end else if (pick < 80) begin
        send_char(8'($urandom));
      end else if (pick < 97) begin
        send_read(5'($urandom_range(NROWS - 1)), 7'($urandom_range(NCOLS - 1)));
      end else begin
        send_read(5'($urandom), 7'($urandom));
      end
    end
  endtask

  // ---- result monitor ------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      beats_out <= beats_out + 1;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_item);
      end else begin
        automatic out_item_t want = pending_q.pop_front();
        if (out_item.cursor_position !== want.cursor_position ||
            out_item.cell_data !== want.cell_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: cursor exp %0d got %0d, cell exp %h got %h", beats_out,
                     want.cursor_position, out_item.cursor_position,
                     want.cell_data, out_item.cell_data);
        end
      end
    end
    pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog: counts cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("timeout after %0d idle cycles", wdog);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  // ---- sequence ------------------------------------------------------------

  initial begin
    blank_from(0);
    cur_row    = 0;
    cur_col    = 0;
    attr_fg    = 4'd15;
    attr_bg    = 3'd0;
    attr_blink = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_attrs(4'd0, 3'd7, 1'b1);
    test_directed();

    // receiver idles more than the sender
    tx_idle_pct = 27;
    rx_idle_pct = 46;
    set_attrs(4'd15, 3'd0, 1'b0);
    test_random(PHASE_LEN);

    // sender idles more than the receiver
    tx_idle_pct = 46;
    rx_idle_pct = 27;
    set_attrs(4'($urandom), 3'($urandom), 1'($urandom));
    test_random(PHASE_LEN);

    // back to back on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_attrs(4'd0, 3'd0, 1'b1);
    test_random(PHASE_LEN / 2);
    set_attrs(4'd15, 3'd7, 1'b0);
    test_random(PHASE_LEN / 2);

    drain();
    $display("%0d beats in, %0d results, %0d scrolls, 5 attribute settings",
             beats_in, beats_out, scrolls);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/tcce_pkg.sv
design/tcce_front.sv
design/tcce_back.sv
design/text_console_character_engine_top.sv
dv/tb.sv
